FILE: design/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and constants for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W + 3;
    localparam int NUM_W     = WORD_W + FRAC_BITS + 2;
    localparam int DEN_W     = WORD_W + 1;
    localparam int QUO_W     = WORD_W;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;
    localparam int DOT_LAT   = 3;
    localparam int DIV_LAT   = QUO_W + 2;
    localparam int TOT_LAT   = DOT_LAT + DIV_LAT;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t value;
        logic  sat;
    } hvt_res_t;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

endpackage

FILE: design/homogeneous_vertex_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// Row vector times 4x4 matrix in Q16.16, then perspective divide by th.
// ----------------------------------------------------------------------------
// One vertex is taken per clock and one result leaves per clock while the
// result side does not stall. From input transfer to result, a vertex passes the
// four column lanes (multiply, pair add, final add with rounding), the three
// divider lanes, which produce one quotient bit per stage, and the output
// register behind the combinational merge. Backpressure on the result
// side stalls the whole pipeline. Matrix writes take effect for vertices
// accepted afterwards and must only be made while the pipeline is empty.
module homogeneous_vertex_transform (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hvt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [127:0]                  s_tdata,  // vx, vy, vz, vh
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [223:0]                  m_tdata,  // tx, ty, tz, th, px, py, pz
    output logic [1:0]                    m_tuser   // weight_zero, saturated
);
    import hvt_pkg::*;

    logic [CFG_W-1:0] coeff_reg [NUM_CFG];
    logic             vld_reg   [TOT_LAT];
    hvt_res_t         t_dly_reg [DIV_LAT][4];
    logic             m_tvalid_reg;
    logic [223:0]     m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic [223:0]     m_tdata_next;
    logic [1:0]       m_tuser_next;

    logic             en;
    word_t            vin  [4];
    word_t            mat  [16];
    word_t            col  [4][4];
    hvt_res_t         tres [4];
    hvt_res_t         pres [3];
    hvt_res_t         tend [4];
    logic             wz;
    logic             any_sat;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            vin[i] = s_tdata[i*WORD_W +: WORD_W];
        end
        for (int k = 0; k < 16; k++)
        begin
            mat[k] = coeff_reg[k >> 1][(k & 1)*WORD_W +: WORD_W];
        end
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                col[j][i] = mat[4*i + j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CFG; k++)
            begin
                coeff_reg[k] <= CFG_RESET[k];
            end
        end
        else if (cfg_valid && !cfg_index[CFG_IDX_W-1])
        begin
            coeff_reg[cfg_index[CFG_IDX_W-2:0]] <= cfg_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_dot
            hvt_dot_lane u_dot (
                .clk (clk),
                .en  (en),
                .v   (vin),
                .m   (col[g]),
                .res (tres[g])
            );
        end
        for (g = 0; g < 3; g++)
        begin : g_div
            hvt_div_lane u_div (
                .clk (clk),
                .en  (en),
                .num (tres[g].value),
                .den (tres[3].value),
                .res (pres[g])
            );
        end
    endgenerate

    // Carry the transformed vertex alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_dly_reg[0] <= tres;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                t_dly_reg[s] <= t_dly_reg[s-1];
            end
        end
    end

    always_comb
    begin
        tend    = t_dly_reg[DIV_LAT-1];
        wz      = (tend[3].value == '0);
        any_sat = tend[0].sat | tend[1].sat | tend[2].sat | tend[3].sat;
        for (int j = 0; j < 4; j++)
        begin
            m_tdata_next[j*WORD_W +: WORD_W] = tend[j].value;
        end
        for (int j = 0; j < 3; j++)
        begin
            // drop the quotient when the weight is zero
            m_tdata_next[(4+j)*WORD_W +: WORD_W] = wz ? '0 : pres[j].value;
            any_sat = any_sat | (!wz & pres[j].sat);
        end
        m_tuser_next = {any_sat, wz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TOT_LAT; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int s = 1; s < TOT_LAT; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            m_tvalid_reg <= vld_reg[TOT_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: design/hvt_dot_lane.sv
// ----------------------------------------------------------------------------
// hvt_dot_lane
// One output column: four products, summed, rounded and saturated.
// ----------------------------------------------------------------------------
module hvt_dot_lane (
    input  logic              clk,
    input  logic              en,
    input  hvt_pkg::word_t    v [4],
    input  hvt_pkg::word_t    m [4],
    output hvt_pkg::hvt_res_t res
);
    import hvt_pkg::*;

    logic signed [PROD_W-1:0]  prod_reg [4];
    logic signed [PROD_W:0]    pair_reg [2];
    hvt_res_t                  res_reg;
    hvt_res_t                  res_next;
    logic signed [SUM_W-1:0]   sum_full;
    logic signed [SUM_W-1:0]   sum_shr;
    logic [SUM_W-WORD_W:0]     sum_top;

    always_comb
    begin
        sum_full = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) + ROUND_HALF;
        sum_shr  = sum_full >>> FRAC_BITS;
        sum_top  = sum_shr[SUM_W-1:WORD_W-1];
        if ((&sum_top) || !(|sum_top))
        begin
            res_next.value = sum_shr[WORD_W-1:0];
            res_next.sat   = 1'b0;
        end
        else
        begin
            // clip towards the sign of the sum
            res_next.value = sum_shr[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                              : {1'b0, {(WORD_W-1){1'b1}}};
            res_next.sat   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= PROD_W'(v[i]) * PROD_W'(m[i]);
            end
            pair_reg[0] <= (PROD_W+1)'(prod_reg[0]) + (PROD_W+1)'(prod_reg[1]);
            pair_reg[1] <= (PROD_W+1)'(prod_reg[2]) + (PROD_W+1)'(prod_reg[3]);
            res_reg     <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: design/hvt_div_lane.sv
// ----------------------------------------------------------------------------
// hvt_div_lane
// Pipelined restoring divider: one quotient bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module hvt_div_lane (
    input  logic              clk,
    input  logic              en,
    input  hvt_pkg::word_t    num,
    input  hvt_pkg::word_t    den,
    output hvt_pkg::hvt_res_t res
);
    import hvt_pkg::*;

    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W+1];
    logic [QUO_W-1:0]  nlo_reg  [QUO_W];
    logic [DEN_W-1:0]  dv_reg   [QUO_W];
    logic              neg_reg  [QUO_W+1];
    logic              ovf_reg  [QUO_W+1];
    hvt_res_t          res_reg;
    hvt_res_t          res_next;

    logic [WORD_W-1:0] un;
    logic [WORD_W-1:0] ud;
    logic [NUM_W-1:0]  n_full;
    logic [DEN_W-1:0]  d_full;
    logic [DEN_W:0]    trial [QUO_W];
    logic [DEN_W:0]    diff  [QUO_W];
    logic [QUO_W-1:0]  q;

    // Numerator 2|n|*2^F + |d|, denominator 2|d|
    always_comb
    begin
        un     = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
        ud     = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
        n_full = (NUM_W'(un) << (FRAC_BITS + 1)) + NUM_W'(ud);
        d_full = {ud, 1'b0};
    end

    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            trial[s] = {rem_reg[s], nlo_reg[s][QUO_W-1-s]};
            diff[s]  = trial[s] - (DEN_W+1)'(dv_reg[s]);
        end
    end

    always_comb
    begin
        q = quo_reg[QUO_W];
        if (neg_reg[QUO_W])
        begin
            if (ovf_reg[QUO_W] || (q[QUO_W-1] && (|q[QUO_W-2:0])))
            begin
                res_next.value = {1'b1, {(WORD_W-1){1'b0}}};
                res_next.sat   = 1'b1;
            end
            else
            begin
                res_next.value = -q;
                res_next.sat   = 1'b0;
            end
        end
        else
        begin
            if (ovf_reg[QUO_W] || q[QUO_W-1])
            begin
                res_next.value = {1'b0, {(WORD_W-1){1'b1}}};
                res_next.sat   = 1'b1;
            end
            else
            begin
                res_next.value = q;
                res_next.sat   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(n_full[NUM_W-1:QUO_W]);
            quo_reg[0] <= '0;
            nlo_reg[0] <= n_full[QUO_W-1:0];
            dv_reg[0]  <= d_full;
            neg_reg[0] <= num[WORD_W-1] ^ den[WORD_W-1];
            ovf_reg[0] <= (DEN_W+1)'(n_full[NUM_W-1:QUO_W]) >= (DEN_W+1)'(d_full);
            for (int s = 0; s < QUO_W; s++)
            begin
                if (!diff[s][DEN_W])
                begin
                    quo_reg[s+1] <= {quo_reg[s][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[s+1] <= {quo_reg[s][QUO_W-2:0], 1'b0};
                end
                // the last stage only needs its quotient bit
                if (s < QUO_W - 1)
                begin
                    if (!diff[s][DEN_W])
                    begin
                        rem_reg[s+1] <= diff[s][DEN_W-1:0];
                    end
                    else
                    begin
                        rem_reg[s+1] <= trial[s][DEN_W-1:0];
                    end
                    nlo_reg[s+1] <= nlo_reg[s];
                    dv_reg[s+1]  <= dv_reg[s];
                end
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: tb/tb_homogeneous_vertex_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_homogeneous_vertex_transform
// Drives vertices and matrix settings into the homogeneous vertex transform and
// compares every result with a bit-accurate model of the fixed-point transform,
// rounding, saturation and perspective divide, under random idles and stalls.
// ----------------------------------------------------------------------------
module tb_homogeneous_vertex_transform;

    import hvt_pkg::*;

    localparam int LAT_CYCLES = TOT_LAT + 8;

    typedef struct packed {
        logic        sat;
        logic        wzero;
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
        logic [31:0] th;
        logic [31:0] tz;
        logic [31:0] ty;
        logic [31:0] tx;
    } vtx_res_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [127:0]         s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [223:0]         m_tdata;
    logic [1:0]           m_tuser;

    logic [CFG_W-1:0] matrix_regs [NUM_CFG];
    vtx_res_t         pending_results [$];
    int               n_errors = 0;
    int               n_vertices = 0;
    int               n_results = 0;
    int               n_wzero = 0;
    int               n_sat = 0;
    int               burst_left = 0;
    int               stall_mode = 0;

    always #5 clk = ~clk;

    homogeneous_vertex_transform dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Round the full-width sum to nearest (ties up) and clip to 32 bits.
    function automatic logic [31:0] round_clip(input logic signed [95:0] acc,
                                                inout logic sat);
        logic signed [95:0] r;
        r = (acc + (96'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > 96'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (r < -96'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    // Quotient rounded to nearest, ties away from zero.
    function automatic logic [31:0] persp_div(input logic [31:0] n, input logic [31:0] d,
                                               inout logic sat);
        logic         neg;
        logic [95:0]  un;
        logic [95:0]  ud;
        logic [95:0]  q;
        neg = n[31] ^ d[31];
        un = (n[31] ? 96'(-$signed({{64{n[31]}}, n})) : 96'(n)) << FRAC_BITS;
        ud = d[31] ? 96'(-$signed({{64{d[31]}}, d})) : 96'(d);
        q = (2 * un + ud) / (2 * ud);
        if (neg) begin
            if (q > 96'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 96'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic vtx_res_t transform_vertex(input logic [127:0] vin);
        logic signed [31:0] v [4];
        logic signed [31:0] m [16];
        logic signed [95:0] acc;
        logic [31:0]        t [4];
        logic               sat;
        vtx_res_t           r;
        sat = 1'b0;
        for (int i = 0; i < 4; i++) v[i] = vin[32*i +: 32];
        for (int k = 0; k < NUM_CFG; k++) begin
            m[2*k]   = matrix_regs[k][31:0];
            m[2*k+1] = matrix_regs[k][63:32];
        end
        for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int i = 0; i < 4; i++)
                acc += 96'(v[i]) * 96'(m[4*i+j]);
            t[j] = round_clip(acc, sat);
        end
        r = '0;
        r.tx = t[0];
        r.ty = t[1];
        r.tz = t[2];
        r.th = t[3];
        if (t[3] == 0) begin
            r.wzero = 1'b1;
        end else begin
            r.px = persp_div(t[0], t[3], sat);
            r.py = persp_div(t[1], t[3], sat);
            r.pz = persp_div(t[2], t[3], sat);
        end
        r.sat = sat;
        return r;
    endfunction

    // Result side: stall pattern changes every so often, sometimes none at all.
    always @(posedge clk) begin
        if (($urandom % 64) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom % 4) != 0;
            2: m_tready <= ($urandom % 2) != 0;
            default: m_tready <= ($urandom % 8) == 0;
        endcase
    end

    always @(posedge clk) begin
        vtx_res_t got;
        vtx_res_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tuser[1], m_tuser[0], m_tdata};
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.tx !== want.tx) begin
                    $error("tx expected %h actual %h", want.tx, got.tx); n_errors++;
                end
                if (got.ty !== want.ty) begin
                    $error("ty expected %h actual %h", want.ty, got.ty); n_errors++;
                end
                if (got.tz !== want.tz) begin
                    $error("tz expected %h actual %h", want.tz, got.tz); n_errors++;
                end
                if (got.th !== want.th) begin
                    $error("th expected %h actual %h", want.th, got.th); n_errors++;
                end
                if (got.px !== want.px) begin
                    $error("px expected %h actual %h", want.px, got.px); n_errors++;
                end
                if (got.py !== want.py) begin
                    $error("py expected %h actual %h", want.py, got.py); n_errors++;
                end
                if (got.pz !== want.pz) begin
                    $error("pz expected %h actual %h", want.pz, got.pz); n_errors++;
                end
                if (got.wzero !== want.wzero) begin
                    $error("weight_zero expected %b actual %b", want.wzero, got.wzero);
                    n_errors++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated expected %b actual %b", want.sat, got.sat);
                    n_errors++;
                end
                if (want.wzero) n_wzero++;
                if (want.sat) n_sat++;
            end
        end
    end

    // Send one vertex; bursts of random length separated by random gaps.
    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] h);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom % 3 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {h, z, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(transform_vertex({h, z, y, x}));
        n_vertices++;
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_idle();
        finish_sending();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    task automatic write_matrix(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx < NUM_CFG) matrix_regs[idx[CFG_IDX_W-2:0]] = val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000);
        endcase
    endfunction

    task automatic test_identity_extremes();
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000, 32'h0003_0000);
        send_vertex(32'h0, 32'h0, 32'h0, 32'h0);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0002_0000);
        wait_idle();
    endtask

    task automatic test_saturating_matrix();
        for (int k = 0; k < NUM_CFG; k++)
            write_matrix(CFG_IDX_W'(k),
                         (k % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000);
        write_matrix(4'd9, 64'hDEAD_BEEF_0123_4567);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h0000_0001, 32'h0, 32'h0, 32'h0);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0);
        wait_idle();
        for (int k = 0; k < NUM_CFG; k++) write_matrix(CFG_IDX_W'(k), 64'h0);
        send_vertex(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();
    endtask

    task automatic test_divide_cases();
        // Tiny weight forces the quotient to clip; halves check the tie rounding.
        for (int k = 0; k < NUM_CFG; k++) write_matrix(CFG_IDX_W'(k), CFG_RESET[k]);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0000_0001);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0002_0000);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFE_0000);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000);
        send_vertex(32'h8000_0000, 32'h0, 32'h0, 32'h0001_0000);
        send_vertex(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_random_matrices();
        for (int phase = 0; phase < 14; phase++) begin
            for (int k = 0; k < NUM_CFG; k++)
                write_matrix(CFG_IDX_W'(k), {rand_coeff(), rand_coeff()});
            // Now and then zero the weight column, or leave only a tiny last entry, so the zero-weight path is hit.
            if (phase % 4 == 1) begin
                write_matrix(4'd1, {32'h0, matrix_regs[1][31:0]});
                write_matrix(4'd3, {32'h0, matrix_regs[3][31:0]});
                write_matrix(4'd5, {32'h0, matrix_regs[5][31:0]});
                write_matrix(4'd7, {$urandom_range(0, 1) ? 32'h0 : 32'h0000_0001,
                                    matrix_regs[7][31:0]});
            end
            if ($urandom_range(0, 3) == 0)
                write_matrix(CFG_IDX_W'($urandom_range(8, 15)), {$urandom, $urandom});
            repeat (60) send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            wait_idle();
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_CFG; k++) matrix_regs[k] = CFG_RESET[k];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_extremes();
        test_saturating_matrix();
        test_divide_cases();
        test_random_matrices();
        $display("%0d vertices and %0d results checked under identity, clipping, zero",
                 n_vertices, n_results);
        $display("and 14 random matrices: %0d with zero weight, %0d with clipping",
                 n_wzero, n_sat);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("** homogeneous_vertex_transform: PASSED **");
        else
            $display("** homogeneous_vertex_transform: FAILED **");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("** homogeneous_vertex_transform: FAILED **");
        $finish;
    end

endmodule

FILE: homogeneous_vertex_transform.f
design/hvt_pkg.sv
design/hvt_dot_lane.sv
design/hvt_div_lane.sv
design/homogeneous_vertex_transform.sv
tb/tb_homogeneous_vertex_transform.sv
